FILE: rtl/dlsu_pkg.sv
// dlsu_pkg: shared types and constants for the dense layer sgd weight update core
// no dependencies
`timescale 1ns / 1ps

package dlsu_pkg;

    localparam int FRAC_BITS       = 12;
    localparam int RATE_BITS       = 16;
    localparam int INPUTS_MAX_DEF  = 64;
    localparam int NEURONS_MAX_DEF = 64;
    localparam int VALUE_BITS_DEF  = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INPUTS_IN_USE = 2'd1;

    localparam logic [15:0] LEARNING_RATE_RESET = 16'd655;
    localparam logic [6:0]  INPUTS_IN_USE_RESET = 7'd64;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_APPLY = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [5:0]         neuron;
        logic [6:0]         column;
        logic signed [15:0] value;
        logic signed [15:0] error_grad;
        logic signed [15:0] act_deriv;
    } item_t;

    typedef struct packed {
        logic signed [15:0] read_value;
        logic               saturated;
    } result_t;

endpackage

FILE: rtl/dense_layer_sgd_weight_update_core.sv
// dense_layer_sgd_weight_update_core: weight store, sample store and sgd update of one layer
// depends on dlsu_pkg
//
//   channel   signals                              direction   handshake
//   item      start, busy, item                    in          start & !busy
//   result    done, result                         out         one-cycle strobe on done
//   config    cfg_valid, cfg_ready, cfg_index,     in          cfg_valid & cfg_ready
//             cfg_data
//
// write, load and out-of-range items go from dispatch straight back to idle; a read waits in S_RDWAIT.
// apply runs through the single shared multiplier: the S_GRAD and S_STEP states
// form gradient and step, then one weight a cycle through a 3-stage walk.
// rst_n clears control and config registers; the weight and sample stores are not cleared.
// busy stays high from accept until done; the receiver cannot stall, a result is one word.
`timescale 1ns / 1ps

module dense_layer_sgd_weight_update_core #(
    parameter int INPUTS_MAX  = dlsu_pkg::INPUTS_MAX_DEF,
    parameter int NEURONS_MAX = dlsu_pkg::NEURONS_MAX_DEF,
    parameter int VALUE_BITS  = dlsu_pkg::VALUE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  dlsu_pkg::item_t                         item,
    output logic                                    done,
    output dlsu_pkg::result_t                       result,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [dlsu_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [dlsu_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    import dlsu_pkg::*;

    localparam int ROW_WORDS = INPUTS_MAX + 1;
    localparam int WDEPTH    = NEURONS_MAX * ROW_WORDS;
    localparam int WA        = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int SA        = (INPUTS_MAX > 1) ? $clog2(INPUTS_MAX) : 1;
    localparam int MA        = 21;
    localparam int MB        = (VALUE_BITS > 20) ? VALUE_BITS : 20;
    localparam int PW        = MA + MB;
    localparam int SW        = (VALUE_BITS + 10 > 22) ? VALUE_BITS + 10 : 22;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DISP   = 6'b000010,
        S_GRAD   = 6'b000100,
        S_STEP   = 6'b001000,
        S_WALK   = 6'b010000,
        S_RDWAIT = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    item_t                   item_reg;
    logic [WA-1:0]           base_reg;
    logic [15:0]             rate_reg;
    logic [6:0]              inputs_reg;
    logic [6:0]              n_used;
    logic                    row_ok;
    logic                    col_ok;
    logic                    accept;

    logic signed [19:0]      g_reg;
    logic signed [MA-1:0]    step_reg;
    logic signed [MA-1:0]    mul_a;
    logic signed [MB-1:0]    mul_b;
    logic signed [PW-1:0]    mul_p;
    logic signed [PW-1:0]    prod_reg;
    logic signed [PW-1:0]    prod_shift;

    logic                    iss_on_reg;
    logic [6:0]              iss_idx_reg;
    logic                    iss_last;
    logic                    s1_valid_reg, s1_bias_reg;
    logic [6:0]              s1_idx_reg;
    logic                    s2_valid_reg, s2_bias_reg;
    logic [6:0]              s2_idx_reg;
    logic signed [VALUE_BITS-1:0] w_s2_reg;
    logic                    sat_reg;

    logic signed [VALUE_BITS-1:0] wmem [WDEPTH];
    logic signed [VALUE_BITS-1:0] smem [INPUTS_MAX];
    logic signed [VALUE_BITS-1:0] w_rd_reg;
    logic signed [VALUE_BITS-1:0] x_rd_reg;
    logic [WA-1:0]           w_rd_addr;
    logic [WA-1:0]           w_wr_addr;
    logic                    w_we;
    logic                    s_we;
    logic signed [VALUE_BITS-1:0] w_wr_data;

    logic signed [SW-1:0]    delta;
    logic signed [SW-1:0]    diff;
    logic [VALUE_BITS:0]     upd_clip;
    logic [VALUE_BITS:0]     in_clip;

    logic                    done_reg;
    result_t                 result_reg;

    function automatic logic [VALUE_BITS:0] clip_word(input logic signed [SW-1:0] v);
        logic [SW-VALUE_BITS:0] top;
        logic                   ovf;
        logic [VALUE_BITS-1:0]  w;
        top = v[SW-1:VALUE_BITS-1];
        ovf = !((&top) || !(|top));
        w   = ovf ? {v[SW-1], {(VALUE_BITS-1){~v[SW-1]}}} : v[VALUE_BITS-1:0];
        return {ovf, w};
    endfunction

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign n_used = (32'(inputs_reg) > INPUTS_MAX) ? 7'(INPUTS_MAX) : inputs_reg;
    assign row_ok = 32'(item_reg.neuron) < NEURONS_MAX;
    assign col_ok = item_reg.column <= n_used;
    assign iss_last = (iss_idx_reg == n_used);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= LEARNING_RATE_RESET;
            inputs_reg <= INPUTS_IN_USE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LEARNING_RATE: rate_reg   <= cfg_data[15:0];
                CFG_INPUTS_IN_USE: inputs_reg <= cfg_data[6:0];
                default:           ;
            endcase
        end
    end

    // shared multiplier
    always_comb
    begin
        unique case (state_reg)
            S_GRAD:
            begin
                mul_a = MA'(item_reg.error_grad);
                mul_b = MB'(item_reg.act_deriv);
            end
            S_STEP:
            begin
                mul_a = MA'(signed'({1'b0, rate_reg}));
                mul_b = MB'(g_reg);
            end
            default:
            begin
                mul_a = step_reg;
                mul_b = MB'(x_rd_reg);
            end
        endcase
    end

    assign mul_p      = mul_a * mul_b;
    assign prod_shift = prod_reg >>> FRAC_BITS;

    // weight update datapath
    assign delta     = s2_bias_reg ? SW'(step_reg) : SW'(prod_shift);
    assign diff      = SW'(w_s2_reg) - delta;
    assign upd_clip  = clip_word(diff);
    assign in_clip   = clip_word(SW'(item_reg.value));

    always_comb
    begin
        w_we      = 1'b0;
        s_we      = 1'b0;
        w_wr_addr = base_reg + WA'(item_reg.column);
        w_wr_data = in_clip[VALUE_BITS-1:0];
        w_rd_addr = base_reg + WA'(item_reg.column);
        if (state_reg == S_WALK)
        begin
            w_rd_addr = base_reg + WA'(iss_idx_reg);
            w_wr_addr = base_reg + WA'(s2_idx_reg);
            w_wr_data = upd_clip[VALUE_BITS-1:0];
            w_we      = s2_valid_reg;
        end
        else if (state_reg == S_DISP)
        begin
            w_we = (item_reg.kind == KIND_WRITE) && row_ok && col_ok;
            s_we = (item_reg.kind == KIND_LOAD) && (32'(item_reg.column) < INPUTS_MAX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[w_wr_addr] <= w_wr_data;
        end
        w_rd_reg <= wmem[w_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            smem[SA'(item_reg.column)] <= in_clip[VALUE_BITS-1:0];
        end
        x_rd_reg <= smem[SA'(iss_idx_reg)];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
            base_reg <= WA'(32'(item.neuron) * ROW_WORDS);
        end
        if (state_reg == S_GRAD)
        begin
            g_reg <= 20'(mul_p >>> FRAC_BITS);
        end
        if (state_reg == S_STEP)
        begin
            step_reg <= MA'(mul_p >>> RATE_BITS);
        end
        prod_reg    <= mul_p;
        w_s2_reg    <= w_rd_reg;
        s1_idx_reg  <= iss_idx_reg;
        s1_bias_reg <= iss_last;
        s2_idx_reg  <= s1_idx_reg;
        s2_bias_reg <= s1_bias_reg;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_DISP;
            S_DISP:
            begin
                unique case (item_reg.kind)
                    KIND_APPLY: state_next = row_ok ? S_GRAD : S_IDLE;
                    KIND_READ:  state_next = (row_ok && col_ok) ? S_RDWAIT : S_IDLE;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_GRAD:   state_next = S_STEP;
            S_STEP:   state_next = S_WALK;
            S_WALK:   if (s2_valid_reg && s2_bias_reg) state_next = S_IDLE;
            S_RDWAIT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            iss_on_reg   <= 1'b0;
            iss_idx_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sat_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= 1'b0;
            s1_valid_reg <= (state_reg == S_WALK) && iss_on_reg;
            s2_valid_reg <= s1_valid_reg;
            if (state_reg == S_STEP)
            begin
                iss_on_reg  <= 1'b1;
                iss_idx_reg <= '0;
            end
            else if ((state_reg == S_WALK) && iss_on_reg)
            begin
                iss_on_reg  <= !iss_last;
                iss_idx_reg <= iss_idx_reg + 7'd1;
            end
            if (accept)
            begin
                sat_reg <= 1'b0;
            end
            else if (w_we && (state_reg == S_WALK))
            begin
                sat_reg <= sat_reg | upd_clip[VALUE_BITS];
            end
            if ((state_reg != S_IDLE) && (state_next == S_IDLE))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if ((state_reg != S_IDLE) && (state_next == S_IDLE))
        begin
            result_reg.read_value <= '0;
            result_reg.saturated  <= 1'b0;
            if (state_reg == S_RDWAIT)
            begin
                result_reg.read_value <= 16'(w_rd_reg);
            end
            else if (state_reg == S_WALK)
            begin
                result_reg.saturated <= sat_reg | upd_clip[VALUE_BITS];
            end
            else if (w_we || s_we)
            begin
                result_reg.saturated <= in_clip[VALUE_BITS];
            end
        end
    end

    a_walk_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || s2_valid_reg) |-> (state_reg == S_WALK))
        else $error("update pipeline active outside walk");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("done while sequencer busy");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_DISP))
        else $error("accepted item not dispatched");

    a_walk_not_stuck: assert property (@(posedge clk) disable iff (!rst_n)
        !((state_reg == S_WALK) && !iss_on_reg && !s1_valid_reg && !s2_valid_reg))
        else $error("walk stalled with empty pipeline");

    a_walk_ends_on_bias: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WALK) && (state_next == S_IDLE)) |-> (s2_valid_reg && s2_bias_reg))
        else $error("walk left before bias update");

endmodule

FILE: verif/tb.sv
// tb: self-checking bench for dense_layer_sgd_weight_update_core, directed plan then random phases
// depends on dlsu_pkg and the core; each accepted item is predicted and matched against its done word
`timescale 1ns / 1ps

module tb;

    import dlsu_pkg::*;

    localparam int ROW_WORDS   = INPUTS_MAX_DEF + 1;
    localparam int STORE_WORDS = NEURONS_MAX_DEF * ROW_WORDS;
    localparam int RAND_ITEMS  = 1880;
    localparam int PHASES      = 9;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_LIMIT = 10000;
    localparam int TAIL_CYCLES = 80;
    localparam longint WORD_MAX = (longint'(1) <<< (VALUE_BITS_DEF - 1)) - 1;
    localparam longint WORD_MIN = -WORD_MAX - 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        bit                        is_cfg;
        logic [CFG_INDEX_BITS-1:0] cidx;
        logic [CFG_DATA_BITS-1:0]  cdata;
        item_t                     it;
        bit                        typed;
        result_t                   texp;
    } plan_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    item_t                     item_r;
    logic                      done;
    result_t                   result_w;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    bit                        typed_r;
    result_t                   typed_exp_r;

    logic signed [15:0] weight_mem [STORE_WORDS];
    logic signed [15:0] sample_mem [INPUTS_MAX_DEF];
    logic [15:0]        rate_q = LEARNING_RATE_RESET;
    logic [6:0]         n_cfg  = INPUTS_IN_USE_RESET;
    result_t            pending_replies [$];

    bit          w_known [NEURONS_MAX_DEF][ROW_WORDS];
    bit          x_known [INPUTS_MAX_DEF];
    int unsigned hot_rows [8] = '{0, 1, 2, 5, 21, 42, 62, 63};
    plan_row_t   plan [$];

    int unsigned cycle_count  = 0;
    int unsigned fail_count   = 0;
    int unsigned n_items      = 0;
    int unsigned n_applies    = 0;
    int unsigned n_reads      = 0;
    int unsigned n_sat        = 0;
    int unsigned n_cfg_writes = 0;

    dense_layer_sgd_weight_update_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item_r),
        .done      (done),
        .result    (result_w),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int unsigned used_n();
        return (n_cfg > INPUTS_MAX_DEF) ? INPUTS_MAX_DEF : n_cfg;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v, inout bit s);
        if (v > WORD_MAX)
        begin
            s = 1'b1;
            return 16'(WORD_MAX);
        end
        if (v < WORD_MIN)
        begin
            s = 1'b1;
            return 16'(WORD_MIN);
        end
        return 16'(v);
    endfunction

    function automatic result_t layer_update(input item_t it);
        result_t     r;
        bit          s;
        int unsigned n;
        int unsigned base;
        int unsigned i;
        longint      e;
        longint      d;
        longint      g;
        longint      lr;
        longint      step;
        longint      x;
        longint      w;
        longint      delta;
        n = used_n();
        s = 1'b0;
        r.read_value = '0;
        base = it.neuron * ROW_WORDS;
        case (it.kind)
            KIND_WRITE:
            begin
                if (it.column <= n)
                    weight_mem[base + it.column] = clip16(it.value, s);
            end
            KIND_LOAD:
            begin
                if (it.column < INPUTS_MAX_DEF)
                    sample_mem[it.column] = clip16(it.value, s);
            end
            KIND_APPLY:
            begin
                e = it.error_grad;
                d = it.act_deriv;
                lr = rate_q;
                g = (e * d) >>> FRAC_BITS;
                step = (lr * g) >>> RATE_BITS;
                for (i = 0; i < n; i++)
                begin
                    x = sample_mem[i];
                    w = weight_mem[base + i];
                    delta = (step * x) >>> FRAC_BITS;
                    weight_mem[base + i] = clip16(w - delta, s);
                end
                w = weight_mem[base + n];
                weight_mem[base + n] = clip16(w - step, s);
            end
            default:
            begin
                if (it.column <= n)
                    r.read_value = weight_mem[base + it.column];
            end
        endcase
        r.saturated = s;
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("word with no pending item: read_value %0d saturated %0b",
                           result_w.read_value, result_w.saturated);
                    fail_count++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (result_w.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, actual %0d",
                               want.read_value, result_w.read_value);
                        fail_count++;
                    end
                    if (result_w.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0b, actual %0b",
                               want.saturated, result_w.saturated);
                        fail_count++;
                    end
                    if (result_w.saturated === 1'b1)
                        n_sat++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LEARNING_RATE)
                    rate_q = cfg_data[15:0];
                else if (cfg_index == CFG_INPUTS_IN_USE)
                    n_cfg = cfg_data[6:0];
                n_cfg_writes++;
            end
            if (start && !busy)
            begin
                want = layer_update(item_r);
                if (typed_r)
                    want = typed_exp_r;
                pending_replies.push_back(want);
                n_items++;
                if (item_r.kind == KIND_APPLY)
                    n_applies++;
                if (item_r.kind == KIND_READ)
                    n_reads++;
            end
        end
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3, 4:    return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_row();
        if ($urandom_range(0, 3) != 0)
            return hot_rows[$urandom_range(0, 7)];
        return $urandom_range(0, NEURONS_MAX_DEF - 1);
    endfunction

    function automatic int unsigned pick_col(input int unsigned n);
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(0, n);
        return $urandom_range(n + 1, 127);
    endfunction

    // rows are filled before an apply may touch them, in-range reads only hit written words
    function automatic item_t fresh_item();
        item_t       it;
        int unsigned n;
        int unsigned nr;
        int unsigned col;
        int unsigned i;
        int unsigned r;
        bit          found;
        n = used_n();
        it.neuron = 6'($urandom);
        it.column = 7'($urandom);
        it.value = pick_word();
        it.error_grad = pick_word();
        it.act_deriv = pick_word();
        it.kind = KIND_READ;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            nr = hot_rows[$urandom_range(0, 7)];
            it.neuron = 6'(nr);
            found = 1'b0;
            for (i = 0; i < n && !found; i++)
            begin
                if (!x_known[i])
                begin
                    found = 1'b1;
                    it.kind = KIND_LOAD;
                    it.column = 7'(i);
                end
            end
            for (i = 0; i <= n && !found; i++)
            begin
                if (!w_known[nr][i])
                begin
                    found = 1'b1;
                    it.kind = KIND_WRITE;
                    it.column = 7'(i);
                end
            end
            if (!found)
                it.kind = KIND_APPLY;
        end
        else if (r < 50)
        begin
            nr = pick_row();
            col = pick_col(n);
            it.neuron = 6'(nr);
            it.column = 7'(col);
            it.kind = (col <= n && !w_known[nr][col]) ? KIND_WRITE : KIND_READ;
        end
        else if (r < 75)
        begin
            it.neuron = 6'(pick_row());
            it.column = 7'(pick_col(n));
            it.kind = KIND_WRITE;
        end
        else
        begin
            it.kind = KIND_LOAD;
            if ($urandom_range(0, 9) != 0)
                it.column = 7'($urandom_range(0, INPUTS_MAX_DEF - 1));
            else
                it.column = 7'($urandom_range(INPUTS_MAX_DEF, 127));
        end
        return it;
    endfunction

    task automatic idle(input int unsigned k);
        repeat (k)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic issue(input item_t it, input bit typed, input result_t texp);
        int unsigned n;
        @(negedge clk);
        start <= 1'b1;
        item_r <= it;
        typed_r <= typed;
        typed_exp_r <= texp;
        n = used_n();
        if (it.kind == KIND_WRITE && it.column <= n)
            w_known[it.neuron][it.column] = 1'b1;
        if (it.kind == KIND_LOAD && it.column < INPUTS_MAX_DEF)
            x_known[it.column] = 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic settle();
        idle(1);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void plan_item(input kind_t k, input int unsigned nr,
                                      input int unsigned col, input logic [15:0] v,
                                      input logic [15:0] e, input logic [15:0] d,
                                      input bit typed, input logic [15:0] rv, input bit s);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.cidx = '0;
        r.cdata = '0;
        r.it.kind = k;
        r.it.neuron = 6'(nr);
        r.it.column = 7'(col);
        r.it.value = v;
        r.it.error_grad = e;
        r.it.act_deriv = d;
        r.typed = typed;
        r.texp.read_value = rv;
        r.texp.saturated = s;
        plan.push_back(r);
    endfunction

    function automatic void plan_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
                                     input logic [CFG_DATA_BITS-1:0] data);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cidx = idx;
        r.cdata = data;
        plan.push_back(r);
    endfunction

    initial
    begin
        plan_row_t   row;
        item_t       it;
        result_t     none;
        logic [15:0] ph_rate [PHASES];
        logic [15:0] ph_n [PHASES];
        int unsigned p;
        int unsigned k;
        int unsigned burst;
        int unsigned waited;

        rst_n = 1'b0;
        start = 1'b0;
        item_r = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        typed_r = 1'b0;
        typed_exp_r = '0;
        none = '0;

        // defaults after reset: rate 655, 64 inputs
        plan_item(KIND_LOAD,  0,   0, 16'h7FFF, 16'h1234, 16'h4321, 1, 16'h0000, 0);
        plan_item(KIND_LOAD,  0,   1, 16'h8000, 16'hFFFF, 16'h0000, 1, 16'h0000, 0);
        plan_item(KIND_LOAD,  63, 63, 16'h1000, 16'h0000, 16'hFFFF, 1, 16'h0000, 0);
        plan_item(KIND_LOAD,  0,  64, 16'h1234, 16'h0000, 16'h0000, 1, 16'h0000, 0);
        plan_item(KIND_LOAD,  0, 127, 16'hFFFF, 16'h0000, 16'h0000, 1, 16'h0000, 0);
        plan_item(KIND_WRITE, 0,   0, 16'h7FFF, 16'h0000, 16'h0000, 1, 16'h0000, 0);
        plan_item(KIND_WRITE, 0,  64, 16'h8000, 16'h0000, 16'h0000, 1, 16'h0000, 0);
        plan_item(KIND_WRITE, 63,  0, 16'h1234, 16'h0000, 16'h0000, 1, 16'h0000, 0);
        plan_item(KIND_WRITE, 0,  65, 16'h5555, 16'h0000, 16'h0000, 1, 16'h0000, 0);
        plan_item(KIND_READ,  0,   0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'h7FFF, 0);
        plan_item(KIND_READ,  0,  64, 16'h0000, 16'h0000, 16'h0000, 1, 16'h8000, 0);
        plan_item(KIND_READ,  63,  0, 16'h0000, 16'h0000, 16'h0000, 1, 16'h1234, 0);
        plan_item(KIND_READ,  0, 127, 16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 0);
        plan_cfg(CFG_LEARNING_RATE, 16'hFFFF);
        plan_cfg(CFG_INPUTS_IN_USE, 16'd2);
        plan_cfg(CFG_UNUSED, 16'hFFFF);
        plan_item(KIND_WRITE, 0,   1, 16'h0100, 16'h0000, 16'h0000, 1, 16'h0000, 0);
        plan_item(KIND_WRITE, 0,   2, 16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 0);
        // zero gradient leaves the row alone
        plan_item(KIND_APPLY, 0,   0, 16'h5A5A, 16'h0000, 16'h7FFF, 1, 16'h0000, 0);
        plan_item(KIND_READ,  0,   1, 16'h0000, 16'h0000, 16'h0000, 1, 16'h0100, 0);
        plan_item(KIND_APPLY, 0,   0, 16'h0000, 16'h7FFF, 16'h7FFF, 0, 16'h0000, 0);
        plan_item(KIND_READ,  0,   0, 16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, 0);
        plan_item(KIND_READ,  0,   1, 16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, 0);
        plan_item(KIND_READ,  0,   2, 16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, 0);
        plan_item(KIND_APPLY, 0,   0, 16'h0000, 16'h8000, 16'h7FFF, 0, 16'h0000, 0);
        // no inputs: only the bias at column 0 moves
        plan_cfg(CFG_INPUTS_IN_USE, 16'd0);
        plan_item(KIND_APPLY, 0,   0, 16'h0000, 16'h8000, 16'h8000, 0, 16'h0000, 0);
        plan_item(KIND_READ,  0,   0, 16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, 0);
        plan_item(KIND_READ,  0,   1, 16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 0);
        // too many inputs clamps to the maximum
        plan_cfg(CFG_INPUTS_IN_USE, 16'hFF7F);
        plan_cfg(CFG_LEARNING_RATE, 16'h0000);
        plan_item(KIND_READ,  0,  64, 16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, 0);
        plan_item(KIND_READ,  0,  65, 16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 0);

        ph_rate[0] = 16'd655;               ph_n[0] = 16'd64;
        ph_rate[1] = 16'hFFFF;              ph_n[1] = 16'd64;
        ph_rate[2] = 16'h0000;              ph_n[2] = 16'd1;
        ph_rate[3] = 16'($urandom);         ph_n[3] = 16'd1;
        ph_rate[4] = 16'h8000;              ph_n[4] = 16'd0;
        ph_rate[5] = 16'($urandom);         ph_n[5] = {9'($urandom), 7'd100};
        ph_rate[6] = 16'($urandom);         ph_n[6] = 16'($urandom_range(1, 64));
        ph_rate[7] = 16'd1;                 ph_n[7] = 16'd63;
        ph_rate[8] = 16'($urandom);         ph_n[8] = 16'($urandom_range(0, 127));

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_cfg)
            begin
                settle();
                write_cfg(row.cidx, row.cdata);
            end
            else
                issue(row.it, row.typed, row.texp);
        end

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            write_cfg(CFG_LEARNING_RATE, ph_rate[p]);
            write_cfg(CFG_INPUTS_IN_USE, ph_n[p]);
            burst = 0;
            for (k = 0; k < RAND_ITEMS / PHASES; k++)
            begin
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0)
                        idle($urandom_range(1, 8));
                end
                burst--;
                it = fresh_item();
                issue(it, 1'b0, none);
            end
        end

        idle(1);
        waited = 0;
        while (pending_replies.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            $error("%0d items never answered", pending_replies.size());
            fail_count++;
        end

        $display("run: %0d items, %0d applies, %0d reads, %0d config writes",
                 n_items, n_applies, n_reads, n_cfg_writes);
        $display("run: %0d saturated words over %0d rate/width settings, %0d mismatches",
                 n_sat, PHASES, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
